[src/ptic_pkg.sv]
// Package for the tight photon classifier: field widths, region codes,
// effective area and cut tables, and the stage-to-stage payload structs.
// No dependencies.
package ptic_pkg;

    localparam int PT_W    = 14;
    localparam int ETA_W   = 14;
    localparam int RATIO_W = 16;
    localparam int ISO_W   = 16;
    localparam int RHO_W   = 12;
    localparam int BIN_W   = 3;
    localparam int REG_W   = 2;
    localparam int ETA_BINS = 7;

    localparam int AREA_W  = 14;
    localparam int PROD_W  = RHO_W + AREA_W;       // rho times area
    localparam int PTSQ_W  = 2 * PT_W;             // pt squared
    localparam int LIN_W   = 24;                   // coefficient times pt
    localparam int CORR_W  = ISO_W + 16;           // corrected isolation, 2^-22 GeV
    localparam int LIM_W   = 32;                   // isolation limits, 2^-24 GeV
    localparam int CMP_W   = CORR_W + 2;           // corrected isolation in 2^-24 GeV

    localparam logic [PT_W-1:0]  PT_MIN          = 14'd480;
    localparam logic [ETA_W-1:0] ETA_BARREL_EDGE = 14'd1514;
    localparam logic [ETA_W-1:0] ETA_ENDCAP_EDGE = 14'd2560;

    // Upper |eta| edges of bins 0 to 5; bin 6 covers everything above.
    localparam logic [ETA_W-1:0] BIN_EDGE [ETA_BINS-1] = '{
        14'd1024, 14'd1514, 14'd2048, 14'd2253, 14'd2355, 14'd2458
    };

    localparam int ISO_CHG = 0;
    localparam int ISO_NEU = 1;
    localparam int ISO_PHO = 2;

    // Effective areas in Q.16, per bin: charged, neutral, photon.
    localparam logic [AREA_W-1:0] AREA_TAB [ETA_BINS][3] = '{
        '{14'd734, 14'd4378, 14'd7294},
        '{14'd708, 14'd6907, 14'd6246},
        '{14'd695, 14'd5151, 14'd4057},
        '{14'd657, 14'd1527, 14'd5485},
        '{14'd642, 14'd511,  14'd7012},
        '{14'd583, 14'd184,  14'd7943},
        '{14'd570, 14'd898,  14'd9608}
    };

    typedef enum logic [REG_W-1:0] {
        REGION_BARREL = 2'd0,
        REGION_ENDCAP = 2'd1,
        REGION_NONE   = 2'd2
    } t_region;

    typedef struct packed {
        logic [15:0] hoe;
        logic [15:0] width;
        logic [15:0] chg;
        logic [17:0] neu_c0;
        logic [9:0]  neu_c1;
        logic [1:0]  neu_c2;
        logic [17:0] pho_c0;
        logic [8:0]  pho_c1;
    } t_cut_set;

    function automatic t_cut_set cut_of(input t_region region);
        t_cut_set c;
        unique case (region)
            REGION_ENDCAP: begin
                c = '{hoe: 16'd2104, width: 16'd1776, chg: 16'd33882,
                      neu_c0: 18'd177996, neu_c1: 10'd767, neu_c2: 2'd2,
                      pho_c0: 18'd198705, pho_c1: 9'd242};
            end
            default: begin
                c = '{hoe: 16'd1408, width: 16'd653, chg: 16'd42598,
                      neu_c0: 18'd20775, neu_c1: 10'd991, neu_c2: 2'd1,
                      pho_c0: 18'd133956, pho_c1: 9'd263};
            end
        endcase
        return c;
    endfunction

    // Stage 1: decoded eta and registered raw fields.
    typedef struct packed {
        logic               valid;
        logic [PT_W-1:0]    pt;
        logic [BIN_W-1:0]   bin;
        t_region            region;
        logic               qual;
        logic               last;
        logic [RATIO_W-1:0] hoe;
        logic [RATIO_W-1:0] width;
        logic [ISO_W-1:0]   iso_chg;
        logic [ISO_W-1:0]   iso_neu;
        logic [ISO_W-1:0]   iso_pho;
        logic [RHO_W-1:0]   rho;
    } t_s1;

    // Stage 2: products.
    typedef struct packed {
        logic               valid;
        logic [BIN_W-1:0]   bin;
        t_region            region;
        logic               qual;
        logic               last;
        logic [RATIO_W-1:0] hoe;
        logic [RATIO_W-1:0] width;
        logic [ISO_W-1:0]   iso_chg;
        logic [ISO_W-1:0]   iso_neu;
        logic [ISO_W-1:0]   iso_pho;
        logic [PROD_W-1:0]  prod_chg;
        logic [PROD_W-1:0]  prod_neu;
        logic [PROD_W-1:0]  prod_pho;
        logic [PTSQ_W-1:0]  pt_sq;
        logic [LIN_W-1:0]   neu_lin;
        logic [LIN_W-1:0]   pho_lin;
    } t_s2;

    // Stage 3: corrected isolations and limits.
    typedef struct packed {
        logic               valid;
        logic [BIN_W-1:0]   bin;
        t_region            region;
        logic               qual;
        logic               last;
        logic [RATIO_W-1:0] hoe;
        logic [RATIO_W-1:0] width;
        logic [CORR_W-1:0]  corr_chg;
        logic [CORR_W-1:0]  corr_neu;
        logic [CORR_W-1:0]  corr_pho;
        logic [LIM_W-1:0]   neu_lim;
        logic [LIM_W-1:0]   pho_lim;
    } t_s3;

endpackage

[src/ptic_if.sv]
// Channel interfaces for the tight photon classifier: candidate input and
// classification result, each with valid, ready and payload. Uses ptic_pkg.
interface ptic_in_if;
    logic                               valid;
    logic                               ready;
    logic        [ptic_pkg::PT_W-1:0]    pt_value;
    logic signed [ptic_pkg::ETA_W-1:0]   eta_value;
    logic        [ptic_pkg::RATIO_W-1:0] had_over_em;
    logic        [ptic_pkg::RATIO_W-1:0] shower_width;
    logic        [ptic_pkg::ISO_W-1:0]   charged_iso;
    logic        [ptic_pkg::ISO_W-1:0]   neutral_iso;
    logic        [ptic_pkg::ISO_W-1:0]   photon_iso;
    logic        [ptic_pkg::RHO_W-1:0]   energy_density;
    logic                               last_in_event;

    modport source (
        output valid, pt_value, eta_value, had_over_em, shower_width,
               charged_iso, neutral_iso, photon_iso, energy_density, last_in_event,
        input  ready
    );
    modport sink (
        input  valid, pt_value, eta_value, had_over_em, shower_width,
               charged_iso, neutral_iso, photon_iso, energy_density, last_in_event,
        output ready
    );
endinterface

interface ptic_out_if;
    logic                             valid;
    logic                             ready;
    logic                             is_tight;
    logic [ptic_pkg::REG_W-1:0]       region_code;
    logic [ptic_pkg::BIN_W-1:0]       eta_bin;
    logic                             last_out;

    modport source (
        output valid, is_tight, region_code, eta_bin, last_out,
        input  ready
    );
    modport sink (
        input  valid, is_tight, region_code, eta_bin, last_out,
        output ready
    );
endinterface

[src/photon_tight_id_classifier_top.sv]
// Tight photon classifier. An accepted candidate passes through the four register stages
// (decode, mult, corr, cut) in order before its result transaction is valid;
// throughput is one candidate per cycle while the result channel is not stalled.
// A synchronous active-low reset clears every stage valid bit; payload
// registers are not reset. Depends on ptic_pkg, ptic_if and the stage modules.
module photon_tight_id_classifier_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptic_in_if.sink    i_cand,
    ptic_out_if.source o_res
);
    import ptic_pkg::*;

    // Each stage carries a valid bit inside its payload struct, and each stage
    // register advances when it is empty or when the stage after it advances.
    // Bubbles therefore collapse under a stall, and a waiting result does not
    // stop new candidates from entering until the whole pipe is full.
    t_s1  w_s1;
    t_s2  w_s2;
    t_s3  w_s3;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;

    // Stage 1: |eta|, area bin, cut region and the low-pt check.
    ptic_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (i_cand),
        .o_s1    (w_s1),
        .i_ready (w_rdy2)
    );

    // Stage 2: rho times effective areas and the pt products of the limits.
    ptic_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .o_ready (w_rdy2),
        .o_s2    (w_s2),
        .i_ready (w_rdy3)
    );

    // Stage 3: corrected isolations, clamped at zero, and limit sums.
    ptic_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (w_s2),
        .o_ready (w_rdy3),
        .o_s3    (w_s3),
        .i_ready (w_rdy4)
    );

    // Stage 4: cut comparisons into the output register.
    ptic_cut u_cut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s3    (w_s3),
        .o_ready (w_rdy4),
        .o_res   (o_res)
    );

endmodule

[src/ptic_decode.sv]
// First stage: takes the candidate transaction, finds |eta|, its area bin and
// cut region, and registers the fields. Uses ptic_pkg and ptic_in_if.
module ptic_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptic_in_if.sink       i_cand,
    output ptic_pkg::t_s1 o_s1,
    input  logic          i_ready
);
    import ptic_pkg::*;

    t_s1              r_s1;
    t_s1              n_s1;
    logic             w_adv;
    logic [ETA_W-1:0] w_eta_u;
    logic [ETA_W-1:0] w_abs_eta;
    logic [BIN_W-1:0] w_bin;
    t_region          w_region;

    assign w_adv        = !r_s1.valid || i_ready;
    assign i_cand.ready = w_adv;
    assign o_s1         = r_s1;

    always_comb begin
        w_eta_u   = i_cand.eta_value;
        // The most negative code maps to its magnitude, which still fits unsigned.
        w_abs_eta = w_eta_u[ETA_W-1] ? (~w_eta_u + 1'b1) : w_eta_u;

        w_bin = BIN_W'(ETA_BINS - 1);
        for (int i = ETA_BINS - 2; i >= 0; i--) begin
            if (w_abs_eta < BIN_EDGE[i]) begin
                w_bin = BIN_W'(i);
            end
        end

        priority if (w_abs_eta < ETA_BARREL_EDGE) begin
            w_region = REGION_BARREL;
        end else if (w_abs_eta > ETA_BARREL_EDGE && w_abs_eta < ETA_ENDCAP_EDGE) begin
            w_region = REGION_ENDCAP;
        end else begin
            w_region = REGION_NONE;
        end

        n_s1.valid   = i_cand.valid;
        n_s1.pt      = i_cand.pt_value;
        n_s1.bin     = w_bin;
        n_s1.region  = w_region;
        n_s1.qual    = (w_region != REGION_NONE) && (i_cand.pt_value > PT_MIN);
        n_s1.last    = i_cand.last_in_event;
        n_s1.hoe     = i_cand.had_over_em;
        n_s1.width   = i_cand.shower_width;
        n_s1.iso_chg = i_cand.charged_iso;
        n_s1.iso_neu = i_cand.neutral_iso;
        n_s1.iso_pho = i_cand.photon_iso;
        n_s1.rho     = i_cand.energy_density;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (w_adv) begin
            r_s1 <= n_s1;
        end
    end

endmodule

[src/ptic_mult.sv]
// Second stage: rho times effective areas, pt squared and the linear pt
// terms of the isolation limits. Uses ptic_pkg.
module ptic_mult (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptic_pkg::t_s1 i_s1,
    output logic          o_ready,
    output ptic_pkg::t_s2 o_s2,
    input  logic          i_ready
);
    import ptic_pkg::*;

    t_s2      r_s2;
    t_s2      n_s2;
    t_cut_set w_cut;
    logic     w_adv;

    assign w_adv   = !r_s2.valid || i_ready;
    assign o_ready = w_adv;
    assign o_s2    = r_s2;

    always_comb begin
        w_cut = cut_of(i_s1.region);

        n_s2.valid    = i_s1.valid;
        n_s2.bin      = i_s1.bin;
        n_s2.region   = i_s1.region;
        n_s2.qual     = i_s1.qual;
        n_s2.last     = i_s1.last;
        n_s2.hoe      = i_s1.hoe;
        n_s2.width    = i_s1.width;
        n_s2.iso_chg  = i_s1.iso_chg;
        n_s2.iso_neu  = i_s1.iso_neu;
        n_s2.iso_pho  = i_s1.iso_pho;
        n_s2.prod_chg = PROD_W'(i_s1.rho) * PROD_W'(AREA_TAB[i_s1.bin][ISO_CHG]);
        n_s2.prod_neu = PROD_W'(i_s1.rho) * PROD_W'(AREA_TAB[i_s1.bin][ISO_NEU]);
        n_s2.prod_pho = PROD_W'(i_s1.rho) * PROD_W'(AREA_TAB[i_s1.bin][ISO_PHO]);
        n_s2.pt_sq    = PTSQ_W'(i_s1.pt) * PTSQ_W'(i_s1.pt);
        n_s2.neu_lin  = LIN_W'(i_s1.pt) * LIN_W'(w_cut.neu_c1);
        n_s2.pho_lin  = LIN_W'(i_s1.pt) * LIN_W'(w_cut.pho_c1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (w_adv) begin
            r_s2 <= n_s2;
        end
    end

endmodule

[src/ptic_corr.sv]
// Third stage: subtracts the pileup offsets from the isolations with a clamp
// at zero and sums the pt-dependent isolation limits. Uses ptic_pkg.
module ptic_corr (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptic_pkg::t_s2 i_s2,
    output logic          o_ready,
    output ptic_pkg::t_s3 o_s3,
    input  logic          i_ready
);
    import ptic_pkg::*;

    t_s3      r_s3;
    t_s3      n_s3;
    t_cut_set w_cut;
    logic     w_adv;

    assign w_adv   = !r_s3.valid || i_ready;
    assign o_ready = w_adv;
    assign o_s3    = r_s3;

    function automatic logic [CORR_W-1:0] clamp_sub(input logic [ISO_W-1:0]  iso,
                                                    input logic [PROD_W-1:0] prod);
        logic [CORR_W-1:0] a;
        logic [CORR_W-1:0] b;
        a = {iso, 16'd0};
        b = CORR_W'(prod);
        return (a > b) ? (a - b) : '0;
    endfunction

    always_comb begin
        w_cut = cut_of(i_s2.region);

        n_s3.valid    = i_s2.valid;
        n_s3.bin      = i_s2.bin;
        n_s3.region   = i_s2.region;
        n_s3.qual     = i_s2.qual;
        n_s3.last     = i_s2.last;
        n_s3.hoe      = i_s2.hoe;
        n_s3.width    = i_s2.width;
        n_s3.corr_chg = clamp_sub(i_s2.iso_chg, i_s2.prod_chg);
        n_s3.corr_neu = clamp_sub(i_s2.iso_neu, i_s2.prod_neu);
        n_s3.corr_pho = clamp_sub(i_s2.iso_pho, i_s2.prod_pho);
        n_s3.neu_lim  = LIM_W'({w_cut.neu_c0, 8'd0})
                      + LIM_W'({i_s2.neu_lin, 4'd0})
                      + (LIM_W'(i_s2.pt_sq) * LIM_W'(w_cut.neu_c2));
        n_s3.pho_lim  = LIM_W'({w_cut.pho_c0, 8'd0})
                      + LIM_W'({i_s2.pho_lin, 4'd0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
        end else if (w_adv) begin
            r_s3 <= n_s3;
        end
    end

endmodule

[src/ptic_cut.sv]
// Last stage: applies the tight cut set and holds the result transaction in
// the output register. Uses ptic_pkg and ptic_out_if.
module ptic_cut (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptic_pkg::t_s3 i_s3,
    output logic          o_ready,
    ptic_out_if.source    o_res
);
    import ptic_pkg::*;

    logic             r_valid;
    logic             r_tight;
    logic [REG_W-1:0] r_region;
    logic [BIN_W-1:0] r_bin;
    logic             r_last;
    logic             n_tight;
    t_cut_set         w_cut;
    logic             w_adv;

    assign w_adv   = !r_valid || o_res.ready;
    assign o_ready = w_adv;

    assign o_res.valid       = r_valid;
    assign o_res.is_tight    = r_tight;
    assign o_res.region_code = r_region;
    assign o_res.eta_bin     = r_bin;
    assign o_res.last_out    = r_last;

    // Isolations are compared in 2^-24 GeV, four times the corrected scale.
    always_comb begin
        w_cut   = cut_of(i_s3.region);
        n_tight = i_s3.qual
               && (i_s3.hoe < w_cut.hoe)
               && (i_s3.width < w_cut.width)
               && ({i_s3.corr_chg, 2'd0} < CMP_W'({w_cut.chg, 8'd0}))
               && ({i_s3.corr_neu, 2'd0} < CMP_W'(i_s3.neu_lim))
               && ({i_s3.corr_pho, 2'd0} < CMP_W'(i_s3.pho_lim));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_s3.valid) begin
            r_tight  <= n_tight;
            r_region <= i_s3.region;
            r_bin    <= i_s3.bin;
            r_last   <= i_s3.last;
        end
    end

endmodule

[tb/photon_tight_id_classifier_top_test.sv]
// Self-checking testbench for photon_tight_id_classifier_top: it streams photon
// candidates, computes the expected tight verdicts and compares every result transaction.
// Depends on ptic_pkg, ptic_if and the classifier RTL.
module photon_tight_id_classifier_top_test;
    import ptic_pkg::*;

    // A result that stays pending this long with no transaction on either channel
    // means the block has hung. The limit is far above the longest random stall.
    localparam int HANG_LIMIT    = 4000;
    // Cycles allowed for stray results after the last expected one.
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 420;

    // Upper |eta| edges of effective area bins 0 to 5, in 1/1024 units.
    localparam int unsigned EDGE_TAB [6] = '{1024, 1514, 2048, 2253, 2355, 2458};
    localparam int unsigned BARREL_EDGE = 1514;
    localparam int unsigned ENDCAP_EDGE = 2560;
    localparam longint unsigned PT_FLOOR = 480;

    // Effective areas in Q.16, per bin.
    localparam int unsigned AREA_CHG [7] = '{734, 708, 695, 657, 642, 583, 570};
    localparam int unsigned AREA_NEU [7] = '{4378, 6907, 5151, 1527, 511, 184, 898};
    localparam int unsigned AREA_PHO [7] = '{7294, 6246, 4057, 5485, 7012, 7943, 9608};

    // Tight cuts in Q.16. Index 0 is the barrel and index 1 is the endcap.
    localparam longint unsigned HOE_CUT   [2] = '{1408, 2104};
    localparam longint unsigned WIDTH_CUT [2] = '{653, 1776};
    localparam longint unsigned CHG_CUT   [2] = '{42598, 33882};
    localparam longint unsigned NEU_C0    [2] = '{20775, 177996};
    localparam longint unsigned NEU_C1    [2] = '{991, 767};
    localparam longint unsigned NEU_C2    [2] = '{1, 2};
    localparam longint unsigned PHO_C0    [2] = '{133956, 198705};
    localparam longint unsigned PHO_C1    [2] = '{263, 242};

    typedef struct {
        logic        [PT_W-1:0]    pt;
        logic signed [ETA_W-1:0]   eta;
        logic        [RATIO_W-1:0] hoe;
        logic        [RATIO_W-1:0] width;
        logic        [ISO_W-1:0]   chg;
        logic        [ISO_W-1:0]   neu;
        logic        [ISO_W-1:0]   pho;
        logic        [RHO_W-1:0]   rho;
        logic                      last;
    } t_cand;

    typedef struct {
        logic             tight;
        t_region          region;
        logic [BIN_W-1:0] bin;
        logic             last;
    } t_verdict;

    // The scoreboard turns each accepted candidate into its expected verdict and
    // checks the result transactions against those verdicts in order.
    class tight_id_scoreboard;
        t_verdict verdicts[$];
        int       errors;
        int       n_checked;
        int       n_tight;
        int       n_region [3];

        // Raw isolation minus the pileup share, in 2^-22 GeV, floored at zero.
        function automatic longint unsigned iso_after_pileup(logic [ISO_W-1:0] iso,
                                                             logic [RHO_W-1:0] rho,
                                                             int unsigned area);
            longint unsigned raw;
            longint unsigned share;
            raw   = longint'(iso) << 16;
            share = longint'(rho) * longint'(area);
            return (raw > share) ? raw - share : 0;
        endfunction

        function automatic t_verdict classify(t_cand c);
            t_verdict        v;
            int              abs_eta;
            int              r;
            bit              found;
            longint unsigned pt;
            longint unsigned chg;
            longint unsigned neu;
            longint unsigned pho;
            longint unsigned neu_lim;
            longint unsigned pho_lim;
            abs_eta = (c.eta < 0) ? -int'(c.eta) : int'(c.eta);
            v.bin   = 3'd6;
            found   = 1'b0;
            for (int i = 0; i < 6; i++) begin
                if (!found && abs_eta < int'(EDGE_TAB[i])) begin
                    v.bin = i[BIN_W-1:0];
                    found = 1'b1;
                end
            end
            if (abs_eta < int'(BARREL_EDGE)) begin
                v.region = REGION_BARREL;
            end else if (abs_eta > int'(BARREL_EDGE) && abs_eta < int'(ENDCAP_EDGE)) begin
                v.region = REGION_ENDCAP;
            end else begin
                v.region = REGION_NONE;
            end
            v.last  = c.last;
            v.tight = 1'b0;
            pt      = longint'(c.pt);
            if (v.region != REGION_NONE && pt > PT_FLOOR) begin
                r       = (v.region == REGION_ENDCAP) ? 1 : 0;
                chg     = iso_after_pileup(c.chg, c.rho, AREA_CHG[v.bin]) << 2;
                neu     = iso_after_pileup(c.neu, c.rho, AREA_NEU[v.bin]) << 2;
                pho     = iso_after_pileup(c.pho, c.rho, AREA_PHO[v.bin]) << 2;
                neu_lim = (NEU_C0[r] << 8) + ((NEU_C1[r] * pt) << 4) + NEU_C2[r] * pt * pt;
                pho_lim = (PHO_C0[r] << 8) + ((PHO_C1[r] * pt) << 4);
                v.tight = (longint'(c.hoe) < HOE_CUT[r]) && (longint'(c.width) < WIDTH_CUT[r])
                       && (chg < (CHG_CUT[r] << 8)) && (neu < neu_lim) && (pho < pho_lim);
            end
            return v;
        endfunction

        function void note_candidate(t_cand c);
            verdicts.insert(verdicts.size(), classify(c));
        endfunction

        function void check_result(t_verdict got);
            t_verdict want;
            if (verdicts.size() == 0) begin
                $error("result transaction with no candidate pending: tight %0d region %0d",
                       got.tight, got.region);
                errors++;
                return;
            end
            want = verdicts.pop_front();
            n_checked++;
            if (want.tight) n_tight++;
            n_region[want.region]++;
            if (got.tight !== want.tight) begin
                $error("is_tight: expected %0d, actual %0d", want.tight, got.tight);
                errors++;
            end
            if (got.region !== want.region) begin
                $error("region_code: expected %0d, actual %0d", want.region, got.region);
                errors++;
            end
            if (got.bin !== want.bin) begin
                $error("eta_bin: expected %0d, actual %0d", want.bin, got.bin);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_out: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   stall_pct;
    int   quiet_cycles = 0;

    tight_id_scoreboard sb;

    ptic_in_if  cand ();
    ptic_out_if res ();

    photon_tight_id_classifier_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand),
        .o_res   (res)
    );

    always #5 i_clk = ~i_clk;

    // The receiver drops ready in roughly stall_pct cycles out of a hundred. The
    // decision is redrawn every cycle, so stalls fall on every stage of the pipeline.
    always @(posedge i_clk) begin
        res.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Both channels are sampled at the rising edge. All inputs change only by
    // nonblocking assignment, so the sampled values are the ones from before the edge.
    always @(posedge i_clk) begin : monitor
        t_cand    seen;
        t_verdict got;
        if (i_rst_n) begin
            if (cand.valid && cand.ready) begin
                seen.pt    = cand.pt_value;
                seen.eta   = cand.eta_value;
                seen.hoe   = cand.had_over_em;
                seen.width = cand.shower_width;
                seen.chg   = cand.charged_iso;
                seen.neu   = cand.neutral_iso;
                seen.pho   = cand.photon_iso;
                seen.rho   = cand.energy_density;
                seen.last  = cand.last_in_event;
                sb.note_candidate(seen);
            end
            if (res.valid && res.ready) begin
                got.tight  = res.is_tight;
                got.region = t_region'(res.region_code);
                got.bin    = res.eta_bin;
                got.last   = res.last_out;
                sb.check_result(got);
            end
        end
    end

    // The watchdog restarts on any transaction. A run whose quiet count reaches HANG_LIMIT
    // is stopped and reported as a failure.
    always @(posedge i_clk) begin
        if ((cand.valid && cand.ready) || (res.valid && res.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     HANG_LIMIT, sb.verdicts.size());
            $display("photon_tight_id_classifier_top test failed");
            $finish;
        end
    end

    function automatic t_cand mk(int pt, int eta, int hoe, int width, int chg, int neu,
                                 int pho, int rho, int last);
        t_cand c;
        c.pt    = pt[PT_W-1:0];
        c.eta   = eta[ETA_W-1:0];
        c.hoe   = hoe[RATIO_W-1:0];
        c.width = width[RATIO_W-1:0];
        c.chg   = chg[ISO_W-1:0];
        c.neu   = neu[ISO_W-1:0];
        c.pho   = pho[ISO_W-1:0];
        c.rho   = rho[RHO_W-1:0];
        c.last  = last[0];
        return c;
    endfunction

    // Most random candidates look like real photons, with pt over the whole field and
    // eta up to just past the endcap edge. H/E, width and isolations sit around the tight cuts,
    // and the isolations are offset by roughly the pileup share, so tight and non-tight
    // verdicts both come up often. The rest are unrestricted noise over the full field
    // widths, including eta beyond its stated range.
    function automatic t_cand random_candidate();
        t_cand c;
        int    rho;
        if ($urandom_range(99) < 70) begin
            rho     = int'($urandom_range(4095));
            c.pt    = ($urandom_range(9) == 0) ? PT_W'($urandom_range(470, 490))
                                               : PT_W'($urandom_range(16383));
            c.eta   = ETA_W'(int'($urandom_range(5400)) - 2700);
            c.hoe   = RATIO_W'($urandom_range(2500));
            c.width = RATIO_W'($urandom_range(2000));
            c.chg   = ISO_W'(rho / 90 + $urandom_range(60));
            c.neu   = ISO_W'(rho / 10 + $urandom_range(150));
            c.pho   = ISO_W'(rho / 7 + $urandom_range(250));
            c.rho   = RHO_W'(rho);
        end else begin
            c.pt    = PT_W'($urandom_range(16383));
            c.eta   = ($urandom_range(3) == 0) ? ETA_W'($urandom_range(16383))
                                               : ETA_W'(int'($urandom_range(10240)) - 5120);
            c.hoe   = RATIO_W'($urandom_range(65535));
            c.width = RATIO_W'($urandom_range(65535));
            c.chg   = ISO_W'($urandom_range(65535));
            c.neu   = ISO_W'($urandom_range(65535));
            c.pho   = ISO_W'($urandom_range(65535));
            c.rho   = RHO_W'($urandom_range(4095));
        end
        c.last = 1'($urandom_range(1));
        return c;
    endfunction

    // Presents one candidate and returns once its transaction has happened. The
    // sender may then go idle. In that case valid drops now and is raised again by a
    // later call. Otherwise valid stays high into the next candidate.
    task automatic send_candidate(t_cand c, int idle_pct);
        cand.valid          <= 1'b1;
        cand.pt_value       <= c.pt;
        cand.eta_value      <= c.eta;
        cand.had_over_em    <= c.hoe;
        cand.shower_width   <= c.width;
        cand.charged_iso    <= c.chg;
        cand.neutral_iso    <= c.neu;
        cand.photon_iso     <= c.pho;
        cand.energy_density <= c.rho;
        cand.last_in_event  <= c.last;
        @(posedge i_clk);
        while (!cand.ready) @(posedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            cand.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    // Holds the sender off until every expected verdict has been checked.
    task automatic drain_pipeline();
        cand.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall);
        stall_pct = stall;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain_pipeline();
            send_candidate(random_candidate(), idle_pct);
        end
        drain_pipeline();
    endtask

    initial begin
        sb           = new;
        stall_pct    = 0;
        i_rst_n              <= 1'b0;
        cand.valid           <= 1'b0;
        cand.pt_value        <= '0;
        cand.eta_value       <= '0;
        cand.had_over_em     <= '0;
        cand.shower_width    <= '0;
        cand.charged_iso     <= '0;
        cand.neutral_iso     <= '0;
        cand.photon_iso      <= '0;
        cand.energy_density  <= '0;
        cand.last_in_event   <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: pt on both sides of the 30 GeV floor, and every eta bin edge.
        // It also covers the barrel/endcap boundary at exactly 1.479, eta at and past
        // the endcap limit including the field extremes, cuts just inside and outside,
        // a pileup share larger than the raw isolation, and all-ones payloads.
        send_candidate(mk(481, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(480, 0, 0, 0, 0, 0, 0, 0, 1), 0);
        send_candidate(mk(0, 1023, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(16383, 1024, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 1513, 100, 100, 10, 10, 10, 100, 1), 0);
        send_candidate(mk(2000, 1514, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, -1514, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 1515, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, -2048, 2103, 1775, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 2253, 2104, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, -2355, 0, 1776, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 2458, 0, 0, 0, 0, 0, 0, 1), 0);
        send_candidate(mk(2000, 2559, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, -2560, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 5120, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, -5120, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 8191, 0, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, -8192, 0, 0, 0, 0, 0, 0, 1), 0);
        send_candidate(mk(16383, 0, 65535, 65535, 65535, 65535, 65535, 4095, 1), 0);
        send_candidate(mk(2000, 0, 0, 0, 0, 0, 0, 4095, 0), 0);
        send_candidate(mk(2000, 0, 1407, 652, 41, 30, 100, 0, 0), 0);
        send_candidate(mk(2000, 0, 1408, 0, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(2000, 0, 0, 653, 0, 0, 0, 0, 0), 0);
        send_candidate(mk(481, -100, 0, 0, 42, 51, 139, 0, 0), 0);
        drain_pipeline();

        // Random phases: free flow, a mostly idle sender, a mostly stalled receiver,
        // and both throttled at once.
        run_phase(0, 0);
        run_phase(83, 0);
        run_phase(0, 83);
        run_phase(26, 26);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.verdicts.size() != 0) begin
            $error("%0d expected results never arrived", sb.verdicts.size());
            sb.errors++;
        end
        $display("Checked %0d candidates in directed, free-flow and throttled phases.",
                 sb.n_checked);
        $display("Verdicts: %0d tight; %0d barrel, %0d endcap, %0d outside both regions.",
                 sb.n_tight, sb.n_region[0], sb.n_region[1], sb.n_region[2]);
        if (sb.errors == 0) begin
            $display("photon_tight_id_classifier_top test passed");
        end else begin
            $display("photon_tight_id_classifier_top test failed");
        end
        $finish;
    end

endmodule
